// ===== sv/ttf_pkg.sv =====
// Types and constants shared by the triangle tangent frame block.
`timescale 1ns / 1ps
package ttf_pkg;

  localparam int PosW   = 32;
  localparam int TexW   = 16;
  localparam int EdgeW  = PosW + 1;
  localparam int DeltaW = TexW + 1;
  localparam int ProdW  = DeltaW + EdgeW;
  localparam int VecW   = ProdW + 1;
  localparam int MagW   = 30;
  localparam int SumW   = 2 * MagW + 2;
  localparam int BitW   = SumW + 1;
  localparam int RootW  = MagW + 1;
  localparam int UnitSh = 14;
  localparam int QuoW   = UnitSh + 1;
  localparam int RemW   = MagW + UnitSh + 2;
  localparam int OutW   = 16;
  localparam int QDepth = 2;
  localparam int QPtrW  = 1;
  localparam int MulSteps = 14;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic signed [TexW-1:0] tex_u;
    logic signed [TexW-1:0] tex_v;
  } vertex_t;

  typedef struct packed {
    logic signed [OutW-1:0] tangent_x;
    logic signed [OutW-1:0] tangent_y;
    logic signed [OutW-1:0] tangent_z;
    logic signed [OutW-1:0] binormal_x;
    logic signed [OutW-1:0] binormal_y;
    logic signed [OutW-1:0] binormal_z;
    logic                   degenerate;
  } frame_t;

  typedef struct packed {
    logic [2:0][EdgeW-1:0]    e1;
    logic [2:0][EdgeW-1:0]    e2;
    logic signed [DeltaW-1:0] du1;
    logic signed [DeltaW-1:0] dv1;
    logic signed [DeltaW-1:0] du2;
    logic signed [DeltaW-1:0] dv2;
  } tri_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_MUL, BK_CHECK, BK_LOAD, BK_SHIFT, BK_SQ, BK_ROOT, BK_DIV, BK_EMIT
  } back_state_e;

endpackage

// ===== sv/ttf_stream_if.sv =====
// Valid/ready stream interface carrying one request payload.
`timescale 1ns / 1ps
interface ttf_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ttf_front.sv =====
// Front end: holds the first two corners and forms edge and texture deltas.
`timescale 1ns / 1ps
module ttf_front import ttf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ttf_stream_if.sink   vtx_i,
  ttf_stream_if.source tri_o
);

  logic [1:0] count_q, count_d;
  logic signed [PosW-1:0] p1_q [3];
  logic signed [PosW-1:0] p2_q [3];
  logic signed [PosW-1:0] cur [3];
  logic signed [TexW-1:0] u1_q, v1_q, u2_q, v2_q;
  logic third, accept;
  tri_t tri_w;

  assign third  = count_q[1];
  assign cur[0] = vtx_i.data.pos_x;
  assign cur[1] = vtx_i.data.pos_y;
  assign cur[2] = vtx_i.data.pos_z;

  assign tri_o.valid = vtx_i.valid && third;
  assign vtx_i.ready = !third || tri_o.ready;
  assign accept      = vtx_i.valid && vtx_i.ready;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tri_w.e1[k] = EdgeW'(p2_q[k]) - EdgeW'(p1_q[k]);
      tri_w.e2[k] = EdgeW'(cur[k]) - EdgeW'(p1_q[k]);
    end
    tri_w.du1 = DeltaW'(u2_q) - DeltaW'(u1_q);
    tri_w.dv1 = DeltaW'(v2_q) - DeltaW'(v1_q);
    tri_w.du2 = DeltaW'(vtx_i.data.tex_u) - DeltaW'(u1_q);
    tri_w.dv2 = DeltaW'(vtx_i.data.tex_v) - DeltaW'(v1_q);
  end
  assign tri_o.data = tri_w;

  always_comb begin
    count_d = count_q;
    if (accept) begin
      count_d = third ? 2'd0 : count_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !third) begin
      if (!count_q[0]) begin
        for (int k = 0; k < 3; k++) p1_q[k] <= cur[k];
        u1_q <= vtx_i.data.tex_u;
        v1_q <= vtx_i.data.tex_v;
      end else begin
        for (int k = 0; k < 3; k++) p2_q[k] <= cur[k];
        u2_q <= vtx_i.data.tex_u;
        v2_q <= vtx_i.data.tex_v;
      end
    end
  end

endmodule

// ===== sv/ttf_queue.sv =====
// Two-entry request queue between front and back.
`timescale 1ns / 1ps
module ttf_queue import ttf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ttf_stream_if.sink   tri_i,
  ttf_stream_if.source tri_o
);

  tri_t mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic push, pop;

  assign tri_i.ready = cnt_q != (QPtrW+1)'(QDepth);
  assign tri_o.valid = cnt_q != '0;
  assign tri_o.data  = mem_q[rd_q];
  assign push = tri_i.valid && tri_i.ready;
  assign pop  = tri_o.valid && tri_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= tri_i.data;
  end

endmodule

// ===== sv/ttf_back.sv =====
// Back end: cross products, normalization by serial root and divide, result register.
`timescale 1ns / 1ps
module ttf_back import ttf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ttf_stream_if.sink   tri_i,
  ttf_stream_if.source frame_o
);

  back_state_e state_q, state_d;
  tri_t ent_q;
  logic [3:0] step_q, idx_w;
  logic signed [ProdW-1:0] prod_q, hold_q, mul_w;
  logic signed [VecW-1:0]  vec_q [7];
  logic signed [VecW-1:0]  cv [3];
  logic [VecW-1:0] mag_q [3];
  logic [VecW-1:0] mag_w [3];
  logic [VecW-1:0] m_w, m_q;
  logic [2:0] neg_q, neg_w;
  logic vsel_q, deg_q, det_neg, det_zero;
  logic [1:0] sq_cnt_q, sq_idx;
  logic [2*MagW-1:0] sq_q;
  logic [SumW-1:0] s_q, n_q;
  logic [BitW-1:0] res_q, bit_q, root_sum;
  logic [RootW-1:0] len_q;
  logic [1:0] comp_q;
  logic [3:0] qi_q;
  logic [RemW-1:0] rem_q, dvs_w;
  logic [QuoW-1:0] quo_q, quo_w;
  logic signed [OutW-1:0] tn_q [3];
  logic signed [OutW-1:0] bn_q [3];
  logic signed [OutW-1:0] qval_w;
  logic signed [DeltaW-1:0] op_a;
  logic signed [EdgeW-1:0]  op_b;
  logic [2:0] pair;
  logic [1:0] kk;
  logic term2, out_vld_q, emit_go;
  frame_t out_q;

  assign tri_i.ready   = state_q == BK_IDLE;
  assign frame_o.valid = out_vld_q;
  assign frame_o.data  = out_q;
  assign emit_go  = state_q == BK_EMIT && (!out_vld_q || frame_o.ready);
  assign det_neg  = vec_q[0][VecW-1];
  assign det_zero = vec_q[0] == '0;
  assign idx_w    = step_q - 4'd1;

  always_comb begin
    pair  = step_q[3:1];
    term2 = step_q[0];
    kk    = 2'd0;
    if (pair == 3'd0) begin
      op_a = term2 ? ent_q.du2 : ent_q.du1;
      op_b = EdgeW'(term2 ? ent_q.dv1 : ent_q.dv2);
    end else if (pair < 3'd4) begin
      kk   = 2'(pair - 3'd1);
      op_a = term2 ? ent_q.dv1 : ent_q.dv2;
      op_b = $signed(term2 ? ent_q.e2[kk] : ent_q.e1[kk]);
    end else begin
      kk   = 2'(pair - 3'd4);
      op_a = term2 ? ent_q.du2 : ent_q.du1;
      op_b = $signed(term2 ? ent_q.e1[kk] : ent_q.e2[kk]);
    end
  end
  assign mul_w = op_a * op_b;

  // magnitudes and signs of the selected vector, flipped for negative determinant
  always_comb begin
    m_w = '0;
    for (int k = 0; k < 3; k++) begin
      cv[k]    = vec_q[3'(vsel_q ? 4 + k : 1 + k)];
      mag_w[k] = cv[k][VecW-1] ? VecW'(-cv[k]) : VecW'(cv[k]);
      neg_w[k] = det_neg ? (cv[k] > 0) : cv[k][VecW-1];
      if (mag_w[k] > m_w) m_w = mag_w[k];
    end
  end

  assign sq_idx   = (sq_cnt_q == 2'd3) ? 2'd0 : sq_cnt_q;
  assign root_sum = res_q + bit_q;
  assign dvs_w    = RemW'(len_q) << qi_q;
  assign quo_w    = (rem_q >= dvs_w) ? (quo_q | (QuoW'(1) << qi_q)) : quo_q;
  assign qval_w   = neg_q[comp_q] ? -OutW'(quo_w) : OutW'(quo_w);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (tri_i.valid) state_d = BK_MUL;
      BK_MUL:   if (step_q == 4'(MulSteps)) state_d = BK_CHECK;
      BK_CHECK: state_d = det_zero ? BK_EMIT : BK_LOAD;
      BK_LOAD:  state_d = BK_SHIFT;
      BK_SHIFT: begin
        if (m_q == '0) state_d = BK_EMIT;
        else if (m_q[VecW-1:MagW] == '0) state_d = BK_SQ;
      end
      BK_SQ:    if (sq_cnt_q == 2'd3) state_d = BK_ROOT;
      BK_ROOT:  begin
        if (bit_q == '0) state_d = (res_q[RootW-1:0] == '0) ? BK_EMIT : BK_DIV;
      end
      BK_DIV:   begin
        if (qi_q == 4'd0 && comp_q == 2'd2) state_d = vsel_q ? BK_EMIT : BK_LOAD;
      end
      BK_EMIT:  if (emit_go) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit_go) out_vld_q <= 1'b1;
      else if (frame_o.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        ent_q  <= tri_i.data;
        step_q <= 4'd0;
        deg_q  <= 1'b0;
      end
      BK_MUL: begin
        prod_q <= mul_w;
        step_q <= step_q + 4'd1;
        if (step_q != 4'd0) begin
          if (!idx_w[0]) hold_q <= prod_q;
          else vec_q[idx_w[3:1]] <= VecW'(hold_q) - VecW'(prod_q);
        end
      end
      BK_CHECK: begin
        vsel_q <= 1'b0;
        if (det_zero) deg_q <= 1'b1;
      end
      BK_LOAD: begin
        mag_q <= mag_w;
        neg_q <= neg_w;
        m_q   <= m_w;
      end
      BK_SHIFT: begin
        sq_cnt_q <= 2'd0;
        s_q      <= '0;
        if (m_q == '0) begin
          deg_q <= 1'b1;
        end else if (m_q[VecW-1:MagW] != '0) begin
          m_q <= m_q >> 1;
          for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] >> 1;
        end
      end
      BK_SQ: begin
        sq_q     <= mag_q[sq_idx][MagW-1:0] * mag_q[sq_idx][MagW-1:0];
        sq_cnt_q <= sq_cnt_q + 2'd1;
        if (sq_cnt_q != 2'd0) s_q <= s_q + SumW'(sq_q);
        if (sq_cnt_q == 2'd3) begin
          n_q   <= s_q + SumW'(sq_q);
          res_q <= '0;
          bit_q <= BitW'(1) << (SumW - 2);
        end
      end
      BK_ROOT: begin
        if (bit_q != '0) begin
          if ({1'b0, n_q} >= root_sum) begin
            n_q   <= SumW'({1'b0, n_q} - root_sum);
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          len_q  <= res_q[RootW-1:0];
          comp_q <= 2'd0;
          qi_q   <= 4'(UnitSh);
          quo_q  <= '0;
          rem_q  <= RemW'({mag_q[0][MagW-1:0], UnitSh'(0)}) +
                    RemW'(res_q[RootW-1:0] >> 1);
          if (res_q[RootW-1:0] == '0) deg_q <= 1'b1;
        end
      end
      BK_DIV: begin
        if (qi_q == 4'd0) begin
          if (vsel_q) bn_q[comp_q] <= qval_w;
          else tn_q[comp_q] <= qval_w;
          comp_q <= comp_q + 2'd1;
          qi_q   <= 4'(UnitSh);
          quo_q  <= '0;
          if (comp_q != 2'd2) begin
            rem_q <= RemW'({mag_q[2'(comp_q + 2'd1)][MagW-1:0], UnitSh'(0)}) +
                     RemW'(len_q >> 1);
          end else begin
            vsel_q <= 1'b1;
          end
        end else begin
          quo_q <= quo_w;
          qi_q  <= qi_q - 4'd1;
          if (rem_q >= dvs_w) rem_q <= rem_q - dvs_w;
        end
      end
      BK_EMIT: begin
        if (emit_go) begin
          out_q.degenerate <= deg_q;
          out_q.tangent_x  <= deg_q ? '0 : tn_q[0];
          out_q.tangent_y  <= deg_q ? '0 : tn_q[1];
          out_q.tangent_z  <= deg_q ? '0 : tn_q[2];
          out_q.binormal_x <= deg_q ? '0 : bn_q[0];
          out_q.binormal_y <= deg_q ? '0 : bn_q[1];
          out_q.binormal_z <= deg_q ? '0 : bn_q[2];
        end
      end
      default: ;
    endcase
  end

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.valid && frame_o.data.degenerate |->
      frame_o.data.tangent_x == 0 && frame_o.data.tangent_y == 0 &&
      frame_o.data.tangent_z == 0 && frame_o.data.binormal_x == 0 &&
      frame_o.data.binormal_y == 0 && frame_o.data.binormal_z == 0)
    else $error("degenerate result with nonzero vector");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.valid && !frame_o.data.degenerate |->
      frame_o.data.tangent_x >= -16'sd16384 && frame_o.data.tangent_x <= 16'sd16384 &&
      frame_o.data.binormal_x >= -16'sd16384 && frame_o.data.binormal_x <= 16'sd16384)
    else $error("normalized component out of range");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DIV |-> len_q != '0)
    else $error("divide with zero length");

  a_root_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_ROOT |-> $onehot0(bit_q))
    else $error("root trial bit not one-hot");

  a_sq_shifted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_SQ |-> m_q[VecW-1:MagW] == '0)
    else $error("squares taken before magnitude scaling finished");

endmodule

// ===== sv/triangle_tangent_frame.sv =====
// Top level: per-triangle tangent and binormal from a triangle-list vertex stream.
// The first two corners are always accepted and held; the third forms the deltas, is queued
//   and yields a result, with no normalization when the texture determinant is zero.
// The back end takes no new triangle until the last is emitted; it runs a 31-step square
//   root and a 15-step divider for six components; a two-entry queue buffers triangles.
// Reset clears the corner count, queue pointers, sequencer and result valid; held corners keep.
`timescale 1ns / 1ps
module triangle_tangent_frame import ttf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ttf_stream_if.sink   vtx_i,
  ttf_stream_if.source frame_o
);

  ttf_stream_if #(.T(tri_t)) tri_front ();
  ttf_stream_if #(.T(tri_t)) tri_back ();

  ttf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx_i),
    .tri_o  (tri_front)
  );

  ttf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tri_i  (tri_front),
    .tri_o  (tri_back)
  );

  ttf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tri_i   (tri_back),
    .frame_o (frame_o)
  );

endmodule
